// File: design/rgb_pixel_blend_unit_macros.svh
// Assertion macros used by the pixel blend unit checker.
`ifndef RGB_PIXEL_BLEND_UNIT_MACROS_SVH
`define RGB_PIXEL_BLEND_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RPBU_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("rpbu assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define RPBU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("rpbu assertion failed");

`endif

// File: design/rpbu_pkg.sv
// Types and constants shared by the pixel blend unit modules.
`default_nettype none

package rpbu_pkg;

	// Blend mode codes as held in the mode register.
	typedef enum logic [3:0] {
		MODE_MULTIPLY = 4'd0,
		MODE_SCREEN   = 4'd1,
		MODE_SUBTRACT = 4'd2,
		MODE_ADD      = 4'd3,
		MODE_OVERLAY  = 4'd4,
		MODE_ISOLATE  = 4'd5,
		MODE_OFFSET   = 4'd6,
		MODE_SCALE    = 4'd7,
		MODE_COMBINE  = 4'd8
	} blend_mode_t;

	// Configuration register indexes.
	localparam int unsigned REG_IDX_W = 2;
	localparam logic [REG_IDX_W-1:0] REG_BLEND_MODE     = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_CHANNEL_SELECT = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_CHANNEL_AMOUNT = 2'd2;

	localparam int unsigned CFG_DATA_W = 9;
	localparam int unsigned PIX_W      = 8;
	localparam int unsigned AMOUNT_W   = 9;

	// Channel select codes; the unused code acts as red.
	localparam logic [1:0] CH_BLUE  = 2'd0;
	localparam logic [1:0] CH_GREEN = 2'd1;
	localparam logic [1:0] CH_RED   = 2'd2;

	// Rounding bias for division by 255.
	localparam logic [15:0] ROUND_BIAS = 16'd127;

	// Per-channel controls handed from the top level to each lane.
	typedef struct packed {
		blend_mode_t         mode;
		logic                selected;
		logic [AMOUNT_W-1:0] amount;
	} lane_ctrl_t;

endpackage

`default_nettype wire

// File: design/rpbu_cfg.sv
// Configuration register file for the pixel blend unit.
`default_nettype none

module rpbu_cfg
	import rpbu_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  write_en,
	input  wire logic [REG_IDX_W-1:0]  write_index,
	input  wire logic [CFG_DATA_W-1:0] write_data,
	output blend_mode_t                mode,
	output logic [1:0]                 chan_sel,
	output logic [AMOUNT_W-1:0]        amount
);

	blend_mode_t         mode_q;
	logic [1:0]          chan_sel_q;
	logic [AMOUNT_W-1:0] amount_q;

	// Decode the register index and update the addressed register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_MULTIPLY;
			chan_sel_q <= CH_BLUE;
			amount_q   <= '0;
		end else if (write_en) begin
			unique case (write_index)
				REG_BLEND_MODE:     mode_q     <= blend_mode_t'(write_data[3:0]);
				REG_CHANNEL_SELECT: chan_sel_q <= write_data[1:0];
				REG_CHANNEL_AMOUNT: amount_q   <= write_data[AMOUNT_W-1:0];
				default: begin
					// Indexes past the register list are ignored.
				end
			endcase
		end
	end

	assign mode     = mode_q;
	assign chan_sel = chan_sel_q;
	assign amount   = amount_q;

endmodule

`default_nettype wire

// File: design/rpbu_lane.sv
// One color channel of the blend datapath: shared multiplier and mode select.
`default_nettype none

module rpbu_lane
	import rpbu_pkg::*;
(
	input  wire logic [PIX_W-1:0] x,
	input  wire logic [PIX_W-1:0] y,
	input  wire logic [PIX_W-1:0] alt,
	input  wire lane_ctrl_t       ctrl,
	output logic [PIX_W-1:0]      result
);

	logic [PIX_W-1:0]   mul_a;
	logic [PIX_W-1:0]   mul_b;
	logic [2*PIX_W-1:0] prod;
	logic [2*PIX_W-1:0] biased;
	logic [2*PIX_W-1:0] div_sum;
	logic [PIX_W-1:0]   quot;
	logic [PIX_W:0]     add_sum;
	logic [PIX_W+1:0]   off_sum;
	logic [PIX_W-1:0]   sub_val;
	logic [PIX_W-1:0]   add_val;
	logic [PIX_W-1:0]   off_val;
	logic [PIX_W-1:0]   scl_val;

	// Pick multiplier operands. Screen and the upper half of overlay work on
	// the complements, overlay doubles the bottom operand, and scale multiplies by the amount.
	always_comb begin
		mul_a = x;
		mul_b = y;
		case (ctrl.mode)
			MODE_SCREEN: begin
				mul_a = ~x;
				mul_b = ~y;
			end
			MODE_OVERLAY: begin
				if (y[PIX_W-1]) begin
					mul_a = ~x;
					mul_b = {~y[PIX_W-2:0], 1'b0};
				end else begin
					mul_b = {y[PIX_W-2:0], 1'b0};
				end
			end
			MODE_SCALE: begin
				mul_b = ctrl.amount[PIX_W-1:0];
			end
			default: begin
			end
		endcase
	end

	// Round to nearest and divide by 255: q = (v + 1 + (v >> 8)) >> 8.
	assign prod    = mul_a * mul_b;
	assign biased  = prod + ROUND_BIAS;
	assign div_sum = biased + 16'd1 + {8'd0, biased[2*PIX_W-1:PIX_W]};
	assign quot    = div_sum[2*PIX_W-1:PIX_W];

	// Saturating subtract and add.
	assign sub_val = (x > y) ? (x - y) : '0;
	assign add_sum = {1'b0, x} + {1'b0, y};
	assign add_val = add_sum[PIX_W] ? '1 : add_sum[PIX_W-1:0];

	// Signed offset with clamp to the pixel range.
	assign off_sum = {2'b00, x} + {ctrl.amount[AMOUNT_W-1], ctrl.amount};
	always_comb begin
		if (off_sum[PIX_W+1]) begin
			off_val = '0;
		end else if (off_sum[PIX_W]) begin
			off_val = '1;
		end else begin
			off_val = off_sum[PIX_W-1:0];
		end
	end

	// Integer scale: a negative factor gives zero, overflow saturates.
	always_comb begin
		if (ctrl.amount[AMOUNT_W-1]) begin
			scl_val = '0;
		end else if (prod[2*PIX_W-1:PIX_W] != '0) begin
			scl_val = '1;
		end else begin
			scl_val = prod[PIX_W-1:0];
		end
	end

	// Final mode select.
	always_comb begin
		case (ctrl.mode) inside
			MODE_MULTIPLY: result = quot;
			MODE_SCREEN:   result = ~quot;
			MODE_SUBTRACT: result = sub_val;
			MODE_ADD:      result = add_val;
			MODE_OVERLAY:  result = y[PIX_W-1] ? ~quot : quot;
			MODE_OFFSET:   result = ctrl.selected ? off_val : x;
			MODE_SCALE:    result = ctrl.selected ? scl_val : x;
			MODE_ISOLATE,
			MODE_COMBINE:  result = alt;
			default:       result = x;
		endcase
	end

endmodule

`default_nettype wire

// File: design/rgb_pixel_blend_unit.sv
// Top level of the pixel blend unit: request handshake, pipeline registers and lanes.
`default_nettype none

// The unit blends two BGR pixels per request into one result pixel under the
// configured mode and accepts one request every clock while it is not stalled. A
// request is captured in an input register, passes through the per-channel
// logic and lands in the result register, from which it is offered on the
// output. The critical path is the 8x8 multiplier in each channel lane
// followed by the divide-by-255 rounding adder. The output register can hold
// a finished result while the input register takes the next request; the
// block stalls only when both are full. Configuration registers should be
// written only while no request is in flight.

module rgb_pixel_blend_unit
	import rpbu_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  write_en,
	input  wire logic [REG_IDX_W-1:0]  write_index,
	input  wire logic [CFG_DATA_W-1:0] write_data,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic [PIX_W-1:0]      a_blue,
	input  wire logic [PIX_W-1:0]      a_green,
	input  wire logic [PIX_W-1:0]      a_red,
	input  wire logic [PIX_W-1:0]      b_blue,
	input  wire logic [PIX_W-1:0]      b_green,
	input  wire logic [PIX_W-1:0]      b_red,
	input  wire logic [PIX_W-1:0]      c_red,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic [PIX_W-1:0]           out_blue,
	output logic [PIX_W-1:0]           out_green,
	output logic [PIX_W-1:0]           out_red
);

	blend_mode_t         mode;
	logic [1:0]          chan_sel;
	logic [AMOUNT_W-1:0] amount;

	logic             valid_s1;
	logic             valid_s2;
	logic             advance_s1;
	logic [PIX_W-1:0] a_blue_s1, a_green_s1, a_red_s1;
	logic [PIX_W-1:0] b_blue_s1, b_green_s1, b_red_s1;
	logic [PIX_W-1:0] c_red_s1;
	logic [PIX_W-1:0] res_blue_s2, res_green_s2, res_red_s2;

	logic [PIX_W-1:0] iso_val;
	logic [PIX_W-1:0] alt_blue, alt_green, alt_red;
	logic [PIX_W-1:0] lane_blue, lane_green, lane_red;
	lane_ctrl_t       ctrl_blue, ctrl_green, ctrl_red;

	rpbu_cfg u_cfg (
		.clk         (clk),
		.arst_n      (arst_n),
		.write_en    (write_en),
		.write_index (write_index),
		.write_data  (write_data),
		.mode        (mode),
		.chan_sel    (chan_sel),
		.amount      (amount)
	);

	// Stage 1 moves on whenever the result register is empty or being drained.
	assign advance_s1 = !valid_s2 || out_ready;
	assign in_ready   = !valid_s1 || advance_s1;

	// Pipeline valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance_s1) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// Input register captures the request payload.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			a_blue_s1  <= a_blue;
			a_green_s1 <= a_green;
			a_red_s1   <= a_red;
			b_blue_s1  <= b_blue;
			b_green_s1 <= b_green;
			b_red_s1   <= b_red;
			c_red_s1   <= c_red;
		end
	end

	// Channel chosen for isolate mode; the unused select code means red.
	always_comb begin
		if (chan_sel[1]) begin
			iso_val = a_red_s1;
		end else if (chan_sel[0]) begin
			iso_val = a_green_s1;
		end else begin
			iso_val = a_blue_s1;
		end
	end

	// Pass-through values for isolate and combine modes.
	assign alt_blue  = (mode == MODE_ISOLATE) ? iso_val : a_blue_s1;
	assign alt_green = (mode == MODE_ISOLATE) ? iso_val : b_green_s1;
	assign alt_red   = (mode == MODE_ISOLATE) ? iso_val : c_red_s1;

	// Lane controls carry the mode, the amount and whether the lane is selected.
	assign ctrl_blue  = '{mode: mode, selected: (chan_sel == CH_BLUE), amount: amount};
	assign ctrl_green = '{mode: mode, selected: (chan_sel == CH_GREEN), amount: amount};
	assign ctrl_red   = '{mode: mode, selected: chan_sel[1], amount: amount};

	rpbu_lane u_lane_blue (
		.x      (a_blue_s1),
		.y      (b_blue_s1),
		.alt    (alt_blue),
		.ctrl   (ctrl_blue),
		.result (lane_blue)
	);

	rpbu_lane u_lane_green (
		.x      (a_green_s1),
		.y      (b_green_s1),
		.alt    (alt_green),
		.ctrl   (ctrl_green),
		.result (lane_green)
	);

	rpbu_lane u_lane_red (
		.x      (a_red_s1),
		.y      (b_red_s1),
		.alt    (alt_red),
		.ctrl   (ctrl_red),
		.result (lane_red)
	);

	// Result register.
	always_ff @(posedge clk) begin
		if (advance_s1 && valid_s1) begin
			res_blue_s2  <= lane_blue;
			res_green_s2 <= lane_green;
			res_red_s2   <= lane_red;
		end
	end

	assign out_valid = valid_s2;
	assign out_blue  = res_blue_s2;
	assign out_green = res_green_s2;
	assign out_red   = res_red_s2;

endmodule

`default_nettype wire

// File: design/rpbu_checker.sv
// Port-level checker for the pixel blend unit and its bind to the top level.
`default_nettype none
`include "rgb_pixel_blend_unit_macros.svh"

module rpbu_checker
	import rpbu_pkg::*;
(
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             in_valid,
	input wire logic             in_ready,
	input wire logic             out_valid,
	input wire logic             out_ready,
	input wire logic [PIX_W-1:0] out_blue,
	input wire logic [PIX_W-1:0] out_green,
	input wire logic [PIX_W-1:0] out_red
);

	// A stalled result keeps its valid and its pixel.
	`RPBU_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable({out_blue, out_green, out_red}))

	// With the result register empty, the unit always takes a request.
	`RPBU_ASSERT_IMP(a_ready_when_empty, clk, arst_n, !out_valid, in_ready)

	// An accepted request shows up at the output from the result register unless stalled.
	`RPBU_ASSERT_NEXT(a_latency, clk, arst_n, (in_valid && in_ready) ##1 out_ready, out_valid)

	// A result only disappears after it was taken.
	`RPBU_ASSERT_IMP(a_no_drop, clk, arst_n, $fell(out_valid), $past(out_ready))

endmodule

bind rgb_pixel_blend_unit rpbu_checker u_rpbu_checker (.*);

`default_nettype wire

// File: tb/sv/tb_top.sv
// Testbench for the pixel blend unit: request driver, result monitor and blend predictor.
`timescale 1ns / 1ps

module tb_top;
	import rpbu_pkg::*;

	localparam int unsigned CYCLE_LIMIT    = 1000000;
	localparam int unsigned RAND_ITEMS     = 1750;
	localparam int unsigned LONG_HOLD      = 300;
	localparam int unsigned STALL_PHASE    = 3;
	localparam int unsigned DRAIN_CYCLES   = 8;
	localparam int unsigned REPORT_MAX     = 10;
	localparam int unsigned PIX_MAX        = 255;
	localparam logic [REG_IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam logic [1:0] SEL_UNUSED           = 2'd3;
	localparam logic [3:0] MODE_UNDEF_MAX       = 4'hF;

	// One request: two full pixels and the red byte of a third.
	typedef struct packed {
		logic [PIX_W-1:0] a_blue;
		logic [PIX_W-1:0] a_green;
		logic [PIX_W-1:0] a_red;
		logic [PIX_W-1:0] b_blue;
		logic [PIX_W-1:0] b_green;
		logic [PIX_W-1:0] b_red;
		logic [PIX_W-1:0] c_red;
	} pixel_req_t;

	typedef struct packed {
		logic [PIX_W-1:0] blue;
		logic [PIX_W-1:0] green;
		logic [PIX_W-1:0] red;
	} pixel_t;

	logic                  clk         = 1'b0;
	logic                  arst_n      = 1'b0;
	logic                  write_en    = 1'b0;
	logic [REG_IDX_W-1:0]  write_index = '0;
	logic [CFG_DATA_W-1:0] write_data  = '0;
	logic                  in_valid    = 1'b0;
	logic                  in_ready;
	logic [PIX_W-1:0]      a_blue      = '0;
	logic [PIX_W-1:0]      a_green     = '0;
	logic [PIX_W-1:0]      a_red       = '0;
	logic [PIX_W-1:0]      b_blue      = '0;
	logic [PIX_W-1:0]      b_green     = '0;
	logic [PIX_W-1:0]      b_red       = '0;
	logic [PIX_W-1:0]      c_red       = '0;
	logic                  out_valid;
	logic                  out_ready   = 1'b0;
	logic [PIX_W-1:0]      out_blue;
	logic [PIX_W-1:0]      out_green;
	logic [PIX_W-1:0]      out_red;

	// Shadow copy of the configuration registers.
	logic [3:0]                 cfg_mode   = MODE_MULTIPLY;
	logic [1:0]                 cfg_sel    = CH_BLUE;
	logic signed [AMOUNT_W-1:0] cfg_amount = '0;

	pixel_req_t  pixel_requests[$];
	pixel_t      blended_expect[$];
	pixel_req_t  drive_req;
	pixel_req_t  seen_req;
	pixel_t      want_px;
	bit          req_taken    = 1'b0;
	bit          tx_gaps_on   = 1'b0;
	bit          rx_gaps_on   = 1'b0;
	bit          rx_hold_req  = 1'b0;
	int unsigned tx_gap       = 0;
	int unsigned rx_gap       = 0;
	int unsigned rx_hold_left = 0;
	int unsigned cycle_count  = 0;
	int unsigned error_count  = 0;
	int unsigned report_count = 0;

	rgb_pixel_blend_unit u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.write_en    (write_en),
		.write_index (write_index),
		.write_data  (write_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.a_blue      (a_blue),
		.a_green     (a_green),
		.a_red       (a_red),
		.b_blue      (b_blue),
		.b_green     (b_green),
		.b_red       (b_red),
		.c_red       (c_red),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_blue    (out_blue),
		.out_green   (out_green),
		.out_red     (out_red)
	);

	always #5 clk = ~clk;

	// Rounded product of two bytes scaled back into byte range.
	function automatic int unsigned scaled_product(int unsigned x, int unsigned y);
		return (x * y + 127) / PIX_MAX;
	endfunction

	function automatic int unsigned overlay_value(int unsigned x, int unsigned y);
		if (y <= 127) begin
			return scaled_product(2 * x, y);
		end
		return PIX_MAX - scaled_product(2 * (PIX_MAX - x), PIX_MAX - y);
	endfunction

	// Expected result pixel under the current shadow configuration.
	function automatic pixel_t blend_pixel(pixel_req_t rq);
		logic [PIX_W-1:0] a[3];
		logic [PIX_W-1:0] b[3];
		logic [PIX_W-1:0] r[3];
		int               sel;
		int               amt;
		int               sum;
		pixel_t           px;
		a[0] = rq.a_blue;
		a[1] = rq.a_green;
		a[2] = rq.a_red;
		b[0] = rq.b_blue;
		b[1] = rq.b_green;
		b[2] = rq.b_red;
		sel = (cfg_sel == SEL_UNUSED) ? int'(CH_RED) : int'(cfg_sel);
		amt = int'(cfg_amount);
		for (int i = 0; i < 3; i++) begin
			r[i] = a[i];
		end
		case (cfg_mode)
			MODE_MULTIPLY: begin
				for (int i = 0; i < 3; i++) begin
					r[i] = PIX_W'(scaled_product(a[i], b[i]));
				end
			end
			MODE_SCREEN: begin
				for (int i = 0; i < 3; i++) begin
					r[i] = PIX_W'(PIX_MAX - scaled_product(PIX_MAX - a[i], PIX_MAX - b[i]));
				end
			end
			MODE_SUBTRACT: begin
				for (int i = 0; i < 3; i++) begin
					r[i] = (a[i] > b[i]) ? a[i] - b[i] : '0;
				end
			end
			MODE_ADD: begin
				for (int i = 0; i < 3; i++) begin
					sum = int'(a[i]) + int'(b[i]);
					r[i] = (sum > int'(PIX_MAX)) ? PIX_W'(PIX_MAX) : PIX_W'(sum);
				end
			end
			MODE_OVERLAY: begin
				for (int i = 0; i < 3; i++) begin
					r[i] = PIX_W'(overlay_value(a[i], b[i]));
				end
			end
			MODE_ISOLATE: begin
				for (int i = 0; i < 3; i++) begin
					r[i] = a[sel];
				end
			end
			MODE_OFFSET: begin
				sum = int'(a[sel]) + amt;
				if (sum < 0) begin
					r[sel] = '0;
				end else if (sum > int'(PIX_MAX)) begin
					r[sel] = PIX_W'(PIX_MAX);
				end else begin
					r[sel] = PIX_W'(sum);
				end
			end
			MODE_SCALE: begin
				sum = int'(a[sel]) * amt;
				if (amt < 0) begin
					r[sel] = '0;
				end else begin
					r[sel] = (sum > int'(PIX_MAX)) ? PIX_W'(PIX_MAX) : PIX_W'(sum);
				end
			end
			MODE_COMBINE: begin
				r[0] = a[0];
				r[1] = b[1];
				r[2] = rq.c_red;
			end
			default: begin
			end
		endcase
		px.blue  = r[0];
		px.green = r[1];
		px.red   = r[2];
		return px;
	endfunction

	// Idle lengths: mostly none or short, now and then long.
	function automatic int unsigned pick_gap();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 60) begin
			return 0;
		end else if (roll < 90) begin
			return $urandom_range(1, 3);
		end else if (roll < 98) begin
			return $urandom_range(4, 12);
		end
		return $urandom_range(20, 60);
	endfunction

	// Byte values lean toward the edges and the overlay split point.
	function automatic logic [PIX_W-1:0] rand_byte();
		int unsigned roll;
		roll = $urandom_range(0, 9);
		case (roll)
			0: return '0;
			1: return PIX_W'(PIX_MAX);
			2: return PIX_W'(127);
			3: return PIX_W'(128);
			default: return PIX_W'($urandom);
		endcase
	endfunction

	function automatic pixel_req_t rand_req();
		pixel_req_t rq;
		rq.a_blue  = rand_byte();
		rq.a_green = rand_byte();
		rq.a_red   = rand_byte();
		rq.b_blue  = rand_byte();
		rq.b_green = rand_byte();
		rq.b_red   = rand_byte();
		rq.c_red   = rand_byte();
		return rq;
	endfunction

	function automatic pixel_req_t make_req(int ab, int ag, int ar, int bb, int bg, int br,
						int cr);
		pixel_req_t rq;
		rq = '{PIX_W'(ab), PIX_W'(ag), PIX_W'(ar), PIX_W'(bb), PIX_W'(bg), PIX_W'(br),
		       PIX_W'(cr)};
		return rq;
	endfunction

	// One register write; the shadow keeps only the bits the register holds.
	task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		case (idx)
			REG_BLEND_MODE:     cfg_mode   = data[3:0];
			REG_CHANNEL_SELECT: cfg_sel    = data[1:0];
			REG_CHANNEL_AMOUNT: cfg_amount = data[AMOUNT_W-1:0];
			default: begin
			end
		endcase
		@(negedge clk);
		write_en    <= 1'b1;
		write_index <= idx;
		write_data  <= data;
		@(negedge clk);
		write_en    <= 1'b0;
	endtask

	task automatic set_config(logic [CFG_DATA_W-1:0] mode_data,
				  logic [CFG_DATA_W-1:0] sel_data,
				  logic [CFG_DATA_W-1:0] amount_data);
		write_reg(REG_BLEND_MODE, mode_data);
		write_reg(REG_CHANNEL_SELECT, sel_data);
		write_reg(REG_CHANNEL_AMOUNT, amount_data);
	endtask

	// Waits until every request has been sent and has produced its result.
	task automatic wait_idle();
		do begin
			@(posedge clk);
			#1;
		end while (pixel_requests.size() != 0 || blended_expect.size() != 0 || in_valid);
	endtask

	// Request driver: a new request only once the previous one has been taken.
	always @(negedge clk) begin
		if (arst_n && (!in_valid || req_taken)) begin
			if (tx_gap > 0) begin
				tx_gap--;
				in_valid <= 1'b0;
			end else if (pixel_requests.size() > 0) begin
				drive_req = pixel_requests.pop_front();
				a_blue   <= drive_req.a_blue;
				a_green  <= drive_req.a_green;
				a_red    <= drive_req.a_red;
				b_blue   <= drive_req.b_blue;
				b_green  <= drive_req.b_green;
				b_red    <= drive_req.b_red;
				c_red    <= drive_req.c_red;
				in_valid <= 1'b1;
				tx_gap = tx_gaps_on ? pick_gap() : 0;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Result receiver: random back-pressure plus one long hold on request.
	always @(negedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (rx_hold_req) begin
			rx_hold_req = 1'b0;
			rx_hold_left = LONG_HOLD;
			out_ready <= 1'b0;
		end else if (rx_hold_left > 0) begin
			rx_hold_left--;
			out_ready <= 1'b0;
		end else if (rx_gap > 0) begin
			rx_gap--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
			rx_gap = rx_gaps_on ? pick_gap() : 0;
		end
	end

	// Monitor: predict on each accepted request, check each accepted result.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				seen_req = '{a_blue, a_green, a_red, b_blue, b_green, b_red, c_red};
				blended_expect = {blended_expect, blend_pixel(seen_req)};
			end
			if (out_valid && out_ready) begin
				if (blended_expect.size() == 0) begin
					error_count++;
					if (report_count < REPORT_MAX) begin
						report_count++;
						$display("%0t result with nothing expected: b=%0d g=%0d r=%0d",
							 $time, out_blue, out_green, out_red);
					end
				end else begin
					want_px = blended_expect.pop_front();
					if (out_blue !== want_px.blue || out_green !== want_px.green ||
					    out_red !== want_px.red) begin
						error_count++;
						if (report_count < REPORT_MAX) begin
							report_count++;
							$display("%0t mismatch: expected b=%0d g=%0d r=%0d, got b=%0d g=%0d r=%0d",
								 $time, want_px.blue, want_px.green, want_px.red,
								 out_blue, out_green, out_red);
						end
					end
				end
			end
		end
		req_taken = in_valid && in_ready;
	end

	// Cycle counter that ends a hung run.
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("FAIL rgb_pixel_blend_unit");
		$finish;
	end

	// Test sequence: directed phases, then random phases.
	initial begin
		pixel_req_t edge_lo;
		pixel_req_t edge_hi;
		pixel_req_t split_px;
		logic [3:0] mode_pick;
		logic [1:0] sel_pick;
		logic [8:0] amount_pick;
		int unsigned sent;
		int unsigned phase;
		int unsigned n_items;
		int unsigned roll;

		edge_lo  = make_req(0, 128, 255, 255, 127, 128, 0);
		edge_hi  = make_req(255, 127, 1, 0, 128, 255, 255);
		split_px = make_req(200, 60, 128, 127, 128, 0, 77);

		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		// Reset values select multiply; no writes yet.
		@(posedge clk);
		pixel_requests = {pixel_requests, edge_lo};
		pixel_requests = {pixel_requests, edge_hi};
		wait_idle();

		// Screen, subtract, add and overlay on the edge pixels.
		for (int m = MODE_SCREEN; m <= MODE_OVERLAY; m++) begin
			set_config(CFG_DATA_W'(m), CFG_DATA_W'(CH_BLUE), '0);
			tx_gaps_on = 1'b1;
			rx_gaps_on = 1'b1;
			@(posedge clk);
			pixel_requests = {pixel_requests, edge_lo};
			pixel_requests = {pixel_requests, edge_hi};
			if (m == MODE_OVERLAY) begin
				pixel_requests = {pixel_requests, split_px};
			end
			wait_idle();
		end

		// Isolate with the unused select code, which acts as red.
		set_config(CFG_DATA_W'(MODE_ISOLATE), CFG_DATA_W'(SEL_UNUSED), '0);
		@(posedge clk);
		pixel_requests = {pixel_requests, edge_lo};
		pixel_requests = {pixel_requests, edge_hi};
		wait_idle();

		// Offset at both extremes of the amount.
		set_config(CFG_DATA_W'(MODE_OFFSET), CFG_DATA_W'(CH_GREEN), 9'h0FF);
		@(posedge clk);
		pixel_requests = {pixel_requests, edge_lo};
		pixel_requests = {pixel_requests, edge_hi};
		wait_idle();
		set_config(CFG_DATA_W'(MODE_OFFSET), CFG_DATA_W'(CH_BLUE), 9'h100);
		@(posedge clk);
		pixel_requests = {pixel_requests, edge_hi};
		wait_idle();

		// Scale with a negative factor, then a small positive one.
		set_config(CFG_DATA_W'(MODE_SCALE), CFG_DATA_W'(CH_RED), 9'h1FF);
		@(posedge clk);
		pixel_requests = {pixel_requests, edge_hi};
		wait_idle();
		set_config(CFG_DATA_W'(MODE_SCALE), CFG_DATA_W'(CH_BLUE), 9'd2);
		@(posedge clk);
		pixel_requests = {pixel_requests, edge_lo};
		pixel_requests = {pixel_requests, edge_hi};
		wait_idle();

		// Combine, after a write to the unused index that must change nothing.
		set_config(CFG_DATA_W'(MODE_COMBINE), CFG_DATA_W'(CH_RED), 9'h155);
		write_reg(REG_UNUSED, 9'h1FF);
		@(posedge clk);
		pixel_requests = {pixel_requests, edge_lo};
		pixel_requests = {pixel_requests, edge_hi};
		wait_idle();

		// An undefined mode code passes pixel a through.
		set_config(CFG_DATA_W'(MODE_UNDEF_MAX), CFG_DATA_W'(CH_GREEN), 9'h0AA);
		@(posedge clk);
		pixel_requests = {pixel_requests, split_px};
		wait_idle();

		// Random phases, each with its own configuration.
		sent = 0;
		phase = 0;
		while (sent < RAND_ITEMS) begin
			roll = $urandom_range(0, 19);
			if (roll < 18) begin
				mode_pick = 4'($urandom_range(MODE_MULTIPLY, MODE_COMBINE));
			end else begin
				mode_pick = 4'($urandom_range(MODE_COMBINE + 1, MODE_UNDEF_MAX));
			end
			sel_pick = 2'($urandom_range(CH_BLUE, SEL_UNUSED));
			roll = $urandom_range(0, 9);
			case (roll) inside
				0: amount_pick = 9'h100;
				1: amount_pick = 9'h101;
				2: amount_pick = 9'h0FF;
				3: amount_pick = 9'h1FF;
				4: amount_pick = '0;
				5, 6: amount_pick = 9'($urandom_range(0, 4));
				default: amount_pick = 9'($urandom);
			endcase
			if ($urandom_range(0, 3) == 0) begin
				set_config({5'($urandom), mode_pick}, {7'($urandom), sel_pick}, amount_pick);
			end else begin
				set_config(CFG_DATA_W'(mode_pick), CFG_DATA_W'(sel_pick), amount_pick);
			end
			if ($urandom_range(0, 4) == 0) begin
				write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
			end

			n_items = (phase == STALL_PHASE) ? 150 : $urandom_range(20, 120);
			@(posedge clk);
			tx_gaps_on = (phase == STALL_PHASE) ? 1'b0 : ($urandom_range(0, 3) != 0);
			rx_gaps_on = $urandom_range(0, 3) != 0;
			for (int i = 0; i < n_items; i++) begin
				pixel_requests = {pixel_requests, rand_req()};
			end
			// Long receiver hold while the sender keeps offering requests.
			if (phase == STALL_PHASE) begin
				rx_hold_req = 1'b1;
			end
			sent += n_items;
			phase++;
			wait_idle();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (blended_expect.size() != 0) begin
			error_count++;
			$display("%0d expected results never arrived", blended_expect.size());
		end
		if (error_count == 0) begin
			$display("PASS rgb_pixel_blend_unit");
		end else begin
			$display("FAIL rgb_pixel_blend_unit");
		end
		$finish;
	end

endmodule
